// File: rtl/sfl_pkg.sv
package sfl_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int VALUE_BITS = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);
   localparam int CAP_W      = 5;
   localparam int CAP_RESET  = 16;
   localparam int CMP_W      = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int NORM_W     = VALUE_BITS + 1;
   localparam int PROD_W     = 2 * NORM_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_SHOW   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUP       = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_ZERO_DEN  = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      RD_PTR,
      RD_PTR_DEC,
      RD_PTR_INC
   } rd_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_CLEAR,
      PTR_INC,
      PTR_DEC,
      PTR_LOAD_FILL
   } ptr_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_MUL,
      S_SCAN_CMP,
      S_DECIDE,
      S_INS_CHK,
      S_INS_RD,
      S_INS_WR,
      S_INS_NEW,
      S_DEL_CHK,
      S_DEL_RD,
      S_DEL_WR,
      S_SHOW_RD,
      S_SHOW_OUT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load_op;
      ptr_op_type ptr_op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       mul_en;
      logic       cmp_en;
      logic       pos_load;
      logic       wr_shift;
      logic       wr_new;
      logic       fill_inc;
      logic       fill_dec;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_found;
      logic       rsp_entry;
      logic       rsp_last;
   } sfl_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     den_zero;
      logic     cnt_zero;
      logic     full;
      logic     cmp_lt;
      logic     hit;
      logic     ptr_gt_pos;
      logic     ptr_inc_lt_cnt;
      logic     rsp_free;
   } sfl_stat_type;

endpackage

// File: rtl/sfl_ctrl.sv
module sfl_ctrl import sfl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sfl_stat_type stat,
   output sfl_cmd_type  cmd
);

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       found_ff, found_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.mode == MODE_SHOW) begin
               state_in = stat.cnt_zero ? S_DONE : S_SHOW_RD;
            end else if (stat.den_zero) begin
               state_in = S_DONE;
            end else if (stat.mode == MODE_INSERT && stat.full) begin
               state_in = S_DONE;
            end else if (stat.cnt_zero) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD:  state_in = S_SCAN_MUL;
         S_SCAN_MUL: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (stat.cmp_lt && stat.ptr_inc_lt_cnt) state_in = S_SCAN_RD;
            else state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (stat.mode)
               MODE_INSERT: state_in = stat.hit ? S_DONE : S_INS_CHK;
               MODE_REMOVE: state_in = stat.hit ? S_DEL_CHK : S_DONE;
               default:     state_in = S_DONE;
            endcase
         end
         S_INS_CHK: state_in = stat.ptr_gt_pos ? S_INS_RD : S_INS_NEW;
         S_INS_RD:  state_in = S_INS_WR;
         S_INS_WR:  state_in = S_INS_CHK;
         S_INS_NEW: state_in = S_DONE;
         S_DEL_CHK: state_in = stat.ptr_inc_lt_cnt ? S_DEL_RD : S_DONE;
         S_DEL_RD:  state_in = S_DEL_WR;
         S_DEL_WR:  state_in = S_DEL_CHK;
         S_SHOW_RD: state_in = S_SHOW_OUT;
         S_SHOW_OUT: begin
            if (stat.rsp_free) state_in = stat.ptr_inc_lt_cnt ? S_SHOW_RD : S_IDLE;
         end
         S_DONE: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.ptr_op = PTR_HOLD;
      cmd.rd_sel = RD_PTR;
      req_ready  = 1'b0;
      status_in  = status_ff;
      found_in   = found_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_op = 1'b1;
               cmd.ptr_op  = PTR_CLEAR;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            found_in  = 1'b0;
            if (stat.mode == MODE_SHOW) begin
               if (stat.cnt_zero) status_in = ST_EMPTY;
            end else if (stat.den_zero) begin
               status_in = ST_ZERO_DEN;
            end else if (stat.mode == MODE_INSERT && stat.full) begin
               status_in = ST_FULL;
            end
         end
         S_SCAN_RD: begin
            cmd.rd_en = 1'b1;
         end
         S_SCAN_MUL: begin
            cmd.mul_en = 1'b1;
         end
         S_SCAN_CMP: begin
            cmd.cmp_en = 1'b1;
            if (stat.cmp_lt) cmd.ptr_op = PTR_INC;
         end
         S_DECIDE: begin
            cmd.pos_load = 1'b1;
            case (stat.mode)
               MODE_INSERT: begin
                  if (stat.hit) status_in = ST_DUP;
                  else cmd.ptr_op = PTR_LOAD_FILL;
               end
               MODE_REMOVE: begin
                  if (!stat.hit) status_in = ST_NOT_FOUND;
               end
               default: begin
                  found_in = stat.hit;
               end
            endcase
         end
         S_INS_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR_DEC;
         end
         S_INS_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_op   = PTR_DEC;
         end
         S_INS_NEW: begin
            cmd.wr_new   = 1'b1;
            cmd.fill_inc = 1'b1;
         end
         S_DEL_CHK: begin
            if (!stat.ptr_inc_lt_cnt) cmd.fill_dec = 1'b1;
         end
         S_DEL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR_INC;
         end
         S_DEL_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_op   = PTR_INC;
         end
         S_SHOW_RD: begin
            cmd.rd_en = 1'b1;
         end
         S_SHOW_OUT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_OK;
               cmd.rsp_entry  = 1'b1;
               cmd.rsp_last   = !stat.ptr_inc_lt_cnt;
               cmd.ptr_op     = PTR_INC;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = status_ff;
               cmd.rsp_found  = found_ff;
               cmd.rsp_last   = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/sfl_dp.sv
module sfl_dp import sfl_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  sfl_cmd_type                  cmd,
   output sfl_stat_type                 stat,
   input  logic [MODE_W-1:0]            req_mode,
   input  logic signed [VALUE_BITS-1:0] req_numerator,
   input  logic signed [VALUE_BITS-1:0] req_denominator,
   input  logic                         csr_we,
   input  logic [CAP_W-1:0]             csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic                         rsp_found,
   output logic signed [VALUE_BITS-1:0] rsp_entry_numerator,
   output logic signed [VALUE_BITS-1:0] rsp_entry_denominator,
   output logic                         rsp_last,
   output logic [COUNT_W-1:0]           rsp_entry_count
);

   logic [VALUE_BITS-1:0] num_mem [LIST_DEPTH];
   logic [VALUE_BITS-1:0] den_mem [LIST_DEPTH];

   mode_type                  mode_ff;
   logic [VALUE_BITS-1:0]     op_num_ff, op_den_ff;
   logic signed [NORM_W-1:0]  opn_ff, opd_ff, opn_in, opd_in;
   logic signed [NORM_W-1:0]  req_num_ext, req_den_ext;
   logic                      den_zero_ff;

   logic [VALUE_BITS-1:0]     rd_num_ff, rd_den_ff;
   logic signed [NORM_W-1:0]  ent_num_ext, ent_den_ext, en, ed;
   logic signed [PROD_W-1:0]  l_ff, r_ff, l_in, r_in;

   logic [COUNT_W-1:0]        ptr_ff, ptr_in, pos_ff, fill_ff;
   logic [COUNT_W-1:0]        rd_addr_wide;
   logic [IDX_W-1:0]          rd_addr, wr_addr;
   logic [VALUE_BITS-1:0]     wr_num, wr_den;
   logic                      wr_en;
   logic                      hit_ff;
   logic [CAP_W-1:0]          capacity_ff;
   logic [CMP_W-1:0]          cap_wide, fill_wide, depth_wide, cap_eff;
   logic [COUNT_W:0]          ptr_inc_wide;

   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   logic                      rsp_found_ff, rsp_last_ff;
   logic [VALUE_BITS-1:0]     rsp_num_ff, rsp_den_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_free;

   // Fractions are normalized to a positive denominator before cross-multiplying.
   assign req_num_ext = NORM_W'(req_numerator);
   assign req_den_ext = NORM_W'(req_denominator);
   assign opn_in = req_denominator[VALUE_BITS-1] ? -req_num_ext : req_num_ext;
   assign opd_in = req_denominator[VALUE_BITS-1] ? -req_den_ext : req_den_ext;

   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         mode_ff     <= mode_type'(req_mode);
         op_num_ff   <= req_numerator;
         op_den_ff   <= req_denominator;
         opn_ff      <= opn_in;
         opd_ff      <= opd_in;
         den_zero_ff <= (req_denominator == '0);
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_PTR_DEC: rd_addr_wide = ptr_ff - COUNT_W'(1);
         RD_PTR_INC: rd_addr_wide = ptr_ff + COUNT_W'(1);
         default:    rd_addr_wide = ptr_ff;
      endcase
   end

   assign rd_addr = rd_addr_wide[IDX_W-1:0];
   assign wr_addr = ptr_ff[IDX_W-1:0];
   assign wr_en   = cmd.wr_shift || cmd.wr_new;
   assign wr_num  = cmd.wr_new ? op_num_ff : rd_num_ff;
   assign wr_den  = cmd.wr_new ? op_den_ff : rd_den_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         num_mem[wr_addr] <= wr_num;
         den_mem[wr_addr] <= wr_den;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_num_ff <= num_mem[rd_addr];
         rd_den_ff <= den_mem[rd_addr];
      end
   end

   assign ent_num_ext = NORM_W'($signed(rd_num_ff));
   assign ent_den_ext = NORM_W'($signed(rd_den_ff));
   assign en   = rd_den_ff[VALUE_BITS-1] ? -ent_num_ext : ent_num_ext;
   assign ed   = rd_den_ff[VALUE_BITS-1] ? -ent_den_ext : ent_den_ext;
   assign l_in = en * opd_ff;
   assign r_in = opn_ff * ed;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         l_ff <= l_in;
         r_ff <= r_in;
      end
   end

   always_comb begin
      case (cmd.ptr_op)
         PTR_CLEAR:     ptr_in = '0;
         PTR_INC:       ptr_in = ptr_ff + COUNT_W'(1);
         PTR_DEC:       ptr_in = ptr_ff - COUNT_W'(1);
         PTR_LOAD_FILL: ptr_in = fill_ff;
         default:       ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         pos_ff      <= '0;
         fill_ff     <= '0;
         hit_ff      <= 1'b0;
         capacity_ff <= CAP_W'(CAP_RESET);
      end else begin
         ptr_ff <= ptr_in;
         if (cmd.pos_load) pos_ff <= ptr_ff;
         if (cmd.fill_inc) fill_ff <= fill_ff + COUNT_W'(1);
         else if (cmd.fill_dec) fill_ff <= fill_ff - COUNT_W'(1);
         if (cmd.load_op) hit_ff <= 1'b0;
         else if (cmd.cmp_en) hit_ff <= (l_ff == r_ff);
         if (csr_we) capacity_ff <= csr_wdata;
      end
   end

   assign cap_wide     = CMP_W'(capacity_ff);
   assign fill_wide    = CMP_W'(fill_ff);
   assign depth_wide   = CMP_W'(LIST_DEPTH);
   assign cap_eff      = (cap_wide > depth_wide) ? depth_wide : cap_wide;
   assign ptr_inc_wide = (COUNT_W + 1)'(ptr_ff) + (COUNT_W + 1)'(1);

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.mode           = mode_ff;
      stat.den_zero       = den_zero_ff;
      stat.cnt_zero       = (fill_ff == '0);
      stat.full           = (fill_wide >= cap_eff);
      stat.cmp_lt         = (l_ff < r_ff);
      stat.hit            = hit_ff;
      stat.ptr_gt_pos     = (ptr_ff > pos_ff);
      stat.ptr_inc_lt_cnt = (ptr_inc_wide < (COUNT_W + 1)'(fill_ff));
      stat.rsp_free       = rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_found_ff  <= cmd.rsp_found;
         rsp_last_ff   <= cmd.rsp_last;
         rsp_num_ff    <= cmd.rsp_entry ? rd_num_ff : '0;
         rsp_den_ff    <= cmd.rsp_entry ? rd_den_ff : '0;
         rsp_count_ff  <= fill_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_found             = rsp_found_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_entry_numerator   = rsp_num_ff;
   assign rsp_entry_denominator = rsp_den_ff;
   assign rsp_entry_count       = rsp_count_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= COUNT_W'(LIST_DEPTH))
      else $error("Fill level exceeds list depth.");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_inc |-> (fill_wide < cap_eff))
      else $error("Insert committed on a full list.");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (ptr_ff < COUNT_W'(LIST_DEPTH)) && (ptr_ff <= fill_ff))
      else $error("Write pointer out of range.");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> rsp_free)
      else $error("Result loaded over an item not yet taken.");

   a_remove_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_dec |-> hit_ff && !stat.cnt_zero)
      else $error("Remove committed without a matching entry.");
`endif

endmodule

// File: rtl/sorted_fraction_list.sv
// Each item is decoded first; a rejected item goes straight to its result. A search, remove or
// insert then scans the list, and each entry compared is read, multiplied (registered) and
// compared; an insert or remove then moves entries by a read and a write each.
// Show gives one result per entry while the consumer keeps up; one item is worked at a
// time and the next is taken in the cycle after the last result is loaded.
// Reset (synchronous, active high) empties the list and sets the capacity to 16.
module sorted_fraction_list import sfl_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [MODE_W-1:0]            req_mode,
   input  logic signed [VALUE_BITS-1:0] req_numerator,
   input  logic signed [VALUE_BITS-1:0] req_denominator,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic                         rsp_found,
   output logic signed [VALUE_BITS-1:0] rsp_entry_numerator,
   output logic signed [VALUE_BITS-1:0] rsp_entry_denominator,
   output logic                         rsp_last,
   output logic [COUNT_W-1:0]           rsp_entry_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CAP_W-1:0]             csr_wdata
);

   sfl_cmd_type  cmd;
   sfl_stat_type stat;

   assign csr_ready = 1'b1;

   sfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfl_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_mode              (req_mode),
      .req_numerator         (req_numerator),
      .req_denominator       (req_denominator),
      .csr_we                (csr_valid && csr_ready),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_found             (rsp_found),
      .rsp_entry_numerator   (rsp_entry_numerator),
      .rsp_entry_denominator (rsp_entry_denominator),
      .rsp_last              (rsp_last),
      .rsp_entry_count       (rsp_entry_count)
   );

endmodule
